FILE: rtl/dlce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlce_pkg
// Shared widths and controller/datapath interface types for the DMA loop
// command expander.
// ----------------------------------------------------------------------------
package dlce_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned MaskW  = 32;
  localparam int unsigned ShiftW = 5;
  localparam int unsigned LoopW  = 6;
  localparam int unsigned CountW = 7;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
  } dp_stat_t;

endpackage

FILE: rtl/dlce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlce_ctrl
// Sequencer: takes one loop word, then walks the datapath through every
// expanded command until the last one is taken.
// ----------------------------------------------------------------------------
module dlce_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dlce_pkg::dp_cmd_t  cmd_o,
  input  dlce_pkg::dp_stat_t stat_i
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.advance = 1'b1;
          if (stat_i.last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/dlce_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlce_dp
// Loop datapath: holds the current command word, the loop counters and the
// bases, and steps addresses and masks through the nested loops.
// ----------------------------------------------------------------------------
module dlce_dp #(
  parameter int unsigned MAX_COMMANDS = 64,
  parameter int unsigned MASK_WIDTH   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dlce_pkg::dp_cmd_t                   cmd_i,
  output dlce_pkg::dp_stat_t                  stat_o,
  input  logic [dlce_pkg::AddrW-1:0]          base_main_addr_i,
  input  logic [dlce_pkg::AddrW-1:0]          base_local_addr_i,
  input  logic [dlce_pkg::MaskW-1:0]          base_cluster_mask_i,
  input  logic [dlce_pkg::MaskW-1:0]          base_unit_mask_i,
  input  logic [dlce_pkg::AddrW-1:0]          main_step_i,
  input  logic [dlce_pkg::AddrW-1:0]          local_step_i,
  input  logic [dlce_pkg::ShiftW-1:0]         cluster_shift_i,
  input  logic [dlce_pkg::LoopW-1:0]          cluster_passes_i,
  input  logic [dlce_pkg::ShiftW-1:0]         unit_shift_i,
  input  logic [dlce_pkg::LoopW-1:0]          unit_passes_i,
  input  logic [dlce_pkg::LoopW-1:0]          inner_passes_i,
  input  logic [dlce_pkg::CountW-1:0]         total_count_i,
  output logic [dlce_pkg::AddrW-1:0]          out_main_addr_o,
  output logic [dlce_pkg::AddrW-1:0]          out_local_addr_o,
  output logic [dlce_pkg::MaskW-1:0]          out_cluster_mask_o,
  output logic [dlce_pkg::MaskW-1:0]          out_unit_mask_o,
  output logic                                is_last_o
);

  localparam int unsigned NumW = $clog2(MAX_COMMANDS + 1);
  localparam logic [dlce_pkg::CountW-1:0] MaxCnt = dlce_pkg::CountW'(MAX_COMMANDS);

  logic [dlce_pkg::AddrW-1:0]  mm_q, lm_q, base_lm_q, mm_step_q, lm_step_q;
  logic [MASK_WIDTH-1:0]       cl_q, un_q, base_un_q;
  logic [dlce_pkg::ShiftW-1:0] cl_shift_q, un_shift_q;
  logic [dlce_pkg::LoopW-1:0]  cl_len_q, un_len_q, in_len_q;
  logic [dlce_pkg::LoopW-1:0]  c_q, u_q, i_q;
  logic [NumW-1:0]             num_q, limit_q;
  logic [dlce_pkg::CountW-1:0] limit_sat;
  logic                        inner_end, unit_end, cluster_end;

  always_comb begin
    priority if (total_count_i == '0) begin
      limit_sat = dlce_pkg::CountW'(1);
    end else if (total_count_i > MaxCnt) begin
      limit_sat = MaxCnt;
    end else begin
      limit_sat = total_count_i;
    end
  end

  assign inner_end   = (i_q == in_len_q);
  assign unit_end    = (u_q == un_len_q);
  assign cluster_end = (c_q == cl_len_q);

  assign stat_o.last = (num_q == limit_q) || (inner_end && unit_end && cluster_end);

  // loop counters and command index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q     <= '0;
      u_q     <= '0;
      i_q     <= '0;
      num_q   <= '0;
      limit_q <= '0;
    end else if (cmd_i.load) begin
      c_q     <= '0;
      u_q     <= '0;
      i_q     <= '0;
      num_q   <= NumW'(1);
      limit_q <= NumW'(limit_sat);
    end else if (cmd_i.advance) begin
      num_q <= num_q + NumW'(1);
      if (inner_end) begin
        i_q <= '0;
        if (unit_end) begin
          u_q <= '0;
          c_q <= c_q + dlce_pkg::LoopW'(1);
        end else begin
          u_q <= u_q + dlce_pkg::LoopW'(1);
        end
      end else begin
        i_q <= i_q + dlce_pkg::LoopW'(1);
      end
    end
  end

  // command word and bases
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mm_q       <= base_main_addr_i;
      lm_q       <= base_local_addr_i;
      base_lm_q  <= base_local_addr_i;
      mm_step_q  <= main_step_i;
      lm_step_q  <= local_step_i;
      cl_q       <= base_cluster_mask_i[MASK_WIDTH-1:0];
      un_q       <= base_unit_mask_i[MASK_WIDTH-1:0];
      base_un_q  <= base_unit_mask_i[MASK_WIDTH-1:0];
      cl_shift_q <= cluster_shift_i;
      un_shift_q <= unit_shift_i;
      cl_len_q   <= cluster_passes_i;
      un_len_q   <= unit_passes_i;
      in_len_q   <= inner_passes_i;
    end else if (cmd_i.advance) begin
      mm_q <= mm_q + mm_step_q;
      if (inner_end) begin
        lm_q <= base_lm_q;
        if (unit_end) begin
          un_q <= base_un_q;
          cl_q <= cl_q << cl_shift_q;
        end else begin
          un_q <= un_q << un_shift_q;
        end
      end else begin
        lm_q <= lm_q + lm_step_q;
      end
    end
  end

  assign out_main_addr_o    = mm_q;
  assign out_local_addr_o   = lm_q;
  assign out_cluster_mask_o = dlce_pkg::MaskW'(cl_q);
  assign out_unit_mask_o    = dlce_pkg::MaskW'(un_q);
  assign is_last_o          = stat_o.last;

endmodule

FILE: rtl/dma_loop_command_expander.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_loop_command_expander
// Expands one loop-encoded DMA word into its individual DMA commands,
// cluster loop outermost, then unit loop, then inner loop.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid_i / in_stall_o   | loop command
// out     | output    | out_valid_o / out_stall_i | expanded command + is_last
//
// A word is loaded while idle, then one expanded command per cycle while the
// output is not stalled; a word gives at most MAX_COMMANDS (64) commands.
// The command register in the datapath is the output register; a stall
// simply holds it. A new word is taken in the cycle after the last command
// is taken. Reset returns the sequencer to idle; no clearing pass.
// ----------------------------------------------------------------------------
module dma_loop_command_expander #(
  parameter int unsigned MAX_COMMANDS = 64,
  parameter int unsigned MASK_WIDTH   = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [dlce_pkg::AddrW-1:0]         base_main_addr_i,
  input  logic [dlce_pkg::AddrW-1:0]         base_local_addr_i,
  input  logic [dlce_pkg::MaskW-1:0]         base_cluster_mask_i,
  input  logic [dlce_pkg::MaskW-1:0]         base_unit_mask_i,
  input  logic signed [dlce_pkg::AddrW-1:0]  main_step_i,
  input  logic signed [dlce_pkg::AddrW-1:0]  local_step_i,
  input  logic [dlce_pkg::ShiftW-1:0]        cluster_shift_i,
  input  logic [dlce_pkg::LoopW-1:0]         cluster_passes_i,
  input  logic [dlce_pkg::ShiftW-1:0]        unit_shift_i,
  input  logic [dlce_pkg::LoopW-1:0]         unit_passes_i,
  input  logic [dlce_pkg::LoopW-1:0]         inner_passes_i,
  input  logic [dlce_pkg::CountW-1:0]        total_count_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [dlce_pkg::AddrW-1:0]         out_main_addr_o,
  output logic [dlce_pkg::AddrW-1:0]         out_local_addr_o,
  output logic [dlce_pkg::MaskW-1:0]         out_cluster_mask_o,
  output logic [dlce_pkg::MaskW-1:0]         out_unit_mask_o,
  output logic                               is_last_o
);

  dlce_pkg::dp_cmd_t  cmd;
  dlce_pkg::dp_stat_t stat;

  dlce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  dlce_dp #(
    .MAX_COMMANDS (MAX_COMMANDS),
    .MASK_WIDTH   (MASK_WIDTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .base_main_addr_i    (base_main_addr_i),
    .base_local_addr_i   (base_local_addr_i),
    .base_cluster_mask_i (base_cluster_mask_i),
    .base_unit_mask_i    (base_unit_mask_i),
    .main_step_i         ($unsigned(main_step_i)),
    .local_step_i        ($unsigned(local_step_i)),
    .cluster_shift_i     (cluster_shift_i),
    .cluster_passes_i    (cluster_passes_i),
    .unit_shift_i        (unit_shift_i),
    .unit_passes_i       (unit_passes_i),
    .inner_passes_i      (inner_passes_i),
    .total_count_i       (total_count_i),
    .out_main_addr_o     (out_main_addr_o),
    .out_local_addr_o    (out_local_addr_o),
    .out_cluster_mask_o  (out_cluster_mask_o),
    .out_unit_mask_o     (out_unit_mask_o),
    .is_last_o           (is_last_o)
  );

`ifndef NO_ASSERTIONS
  // an accepted loop word always produces at least one command next cycle
  a_load_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("no command after accepted loop word");

  // run ends exactly when the last command is taken
  a_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && is_last_o) |=> !out_valid_o)
    else $error("commands continue past is_last");

  a_more_after_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !is_last_o) |=> out_valid_o)
    else $error("run ended without is_last");

  // no new loop word while a run is in flight
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("loop word accepted during a run");
`endif

endmodule

FILE: test/dma_loop_command_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_loop_command_checker
// Watches both channels of the DMA loop command expander. Every accepted
// loop word is expanded here into the commands it stands for; every word
// leaving the block is compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
module dma_loop_command_checker #(
  parameter int unsigned MAX_COMMANDS = 64,
  parameter int unsigned MASK_WIDTH   = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [dlce_pkg::AddrW-1:0]        base_main_addr_i,
  input  logic [dlce_pkg::AddrW-1:0]        base_local_addr_i,
  input  logic [dlce_pkg::MaskW-1:0]        base_cluster_mask_i,
  input  logic [dlce_pkg::MaskW-1:0]        base_unit_mask_i,
  input  logic [dlce_pkg::AddrW-1:0]        main_step_i,
  input  logic [dlce_pkg::AddrW-1:0]        local_step_i,
  input  logic [dlce_pkg::ShiftW-1:0]       cluster_shift_i,
  input  logic [dlce_pkg::LoopW-1:0]        cluster_passes_i,
  input  logic [dlce_pkg::ShiftW-1:0]       unit_shift_i,
  input  logic [dlce_pkg::LoopW-1:0]        unit_passes_i,
  input  logic [dlce_pkg::LoopW-1:0]        inner_passes_i,
  input  logic [dlce_pkg::CountW-1:0]       total_count_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [dlce_pkg::AddrW-1:0]        out_main_addr_i,
  input  logic [dlce_pkg::AddrW-1:0]        out_local_addr_i,
  input  logic [dlce_pkg::MaskW-1:0]        out_cluster_mask_i,
  input  logic [dlce_pkg::MaskW-1:0]        out_unit_mask_i,
  input  logic                              is_last_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_count_o
);

  typedef struct packed {
    logic [dlce_pkg::AddrW-1:0] main_addr;
    logic [dlce_pkg::AddrW-1:0] local_addr;
    logic [dlce_pkg::MaskW-1:0] cl_mask;
    logic [dlce_pkg::MaskW-1:0] un_mask;
    logic                       last;
  } dma_command_t;

  dma_command_t expected_commands[$];
  dma_command_t oldest;
  int unsigned  mismatch_total;

  task automatic expand_loop_word();
    int unsigned                limit;
    int unsigned                emitted;
    bit                         done;
    logic [dlce_pkg::MaskW-1:0] keep;
    logic [dlce_pkg::AddrW-1:0] main_a;
    logic [dlce_pkg::AddrW-1:0] local_a;
    logic [dlce_pkg::MaskW-1:0] cluster_m;
    logic [dlce_pkg::MaskW-1:0] unit_m;
    dma_command_t               cmd;
    limit = (total_count_i == '0) ? 1 : int'(total_count_i);
    if (limit > MAX_COMMANDS) limit = MAX_COMMANDS;
    keep      = dlce_pkg::MaskW'((64'd1 << MASK_WIDTH) - 64'd1);
    main_a    = base_main_addr_i;
    local_a   = base_local_addr_i;
    cluster_m = base_cluster_mask_i & keep;
    unit_m    = base_unit_mask_i & keep;
    emitted   = 0;
    done      = 1'b0;
    for (int c = 0; c <= int'(cluster_passes_i) && !done; c++) begin
      for (int u = 0; u <= int'(unit_passes_i) && !done; u++) begin
        for (int i = 0; i <= int'(inner_passes_i) && !done; i++) begin
          emitted++;
          done = (emitted >= limit);
          cmd.main_addr  = main_a;
          cmd.local_addr = local_a;
          cmd.cl_mask    = cluster_m;
          cmd.un_mask    = unit_m;
          cmd.last       = done || (c == int'(cluster_passes_i) &&
                           u == int'(unit_passes_i) && i == int'(inner_passes_i));
          expected_commands = {expected_commands, cmd};
          main_a  = main_a + main_step_i;
          local_a = local_a + local_step_i;
        end
        local_a = base_local_addr_i;
        unit_m  = (unit_m << unit_shift_i) & keep;
      end
      unit_m    = base_unit_mask_i & keep;
      cluster_m = (cluster_m << cluster_shift_i) & keep;
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_commands.delete();
      mismatch_total = 0;
      fail_count_o    <= 0;
      pending_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_commands.size() == 0) begin
          $error("unexpected word: main %h local %h", out_main_addr_i, out_local_addr_i);
          mismatch_total++;
        end else begin
          oldest = expected_commands[0];
          expected_commands.delete(0);
          check_field("out_main_addr", oldest.main_addr, out_main_addr_i);
          check_field("out_local_addr", oldest.local_addr, out_local_addr_i);
          check_field("out_cluster_mask", oldest.cl_mask, out_cluster_mask_i);
          check_field("out_unit_mask", oldest.un_mask, out_unit_mask_i);
          check_field("is_last", 32'(oldest.last), 32'(is_last_i));
        end
      end
      if (in_valid_i && !in_stall_i) expand_loop_word();
      fail_count_o    <= mismatch_total;
      pending_count_o <= expected_commands.size();
    end
  end

endmodule

FILE: test/dma_loop_command_expander_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_loop_command_expander_test
// Drives loop words into the DMA loop command expander: a directed set for
// count limits, loop ends, wrapping addresses and masks shifted out, then
// random words, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module dma_loop_command_expander_test;

  localparam int unsigned MaxCommands = 64;
  localparam int unsigned MaskWidth   = 32;
  localparam int unsigned RandomWords = 115;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 100;

  typedef struct packed {
    logic [dlce_pkg::AddrW-1:0]  main_addr;
    logic [dlce_pkg::AddrW-1:0]  local_addr;
    logic [dlce_pkg::MaskW-1:0]  cl_mask;
    logic [dlce_pkg::MaskW-1:0]  un_mask;
    logic [dlce_pkg::AddrW-1:0]  main_step;
    logic [dlce_pkg::AddrW-1:0]  local_step;
    logic [dlce_pkg::ShiftW-1:0] cl_shift;
    logic [dlce_pkg::LoopW-1:0]  cluster_passes;
    logic [dlce_pkg::ShiftW-1:0] un_shift;
    logic [dlce_pkg::LoopW-1:0]  unit_passes;
    logic [dlce_pkg::LoopW-1:0]  inner_passes;
    logic [dlce_pkg::CountW-1:0] total_count;
  } loop_word_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [dlce_pkg::AddrW-1:0]  base_main_addr_i;
  logic [dlce_pkg::AddrW-1:0]  base_local_addr_i;
  logic [dlce_pkg::MaskW-1:0]  base_cluster_mask_i;
  logic [dlce_pkg::MaskW-1:0]  base_unit_mask_i;
  logic [dlce_pkg::AddrW-1:0]  main_step_i;
  logic [dlce_pkg::AddrW-1:0]  local_step_i;
  logic [dlce_pkg::ShiftW-1:0] cluster_shift_i;
  logic [dlce_pkg::LoopW-1:0]  cluster_passes_i;
  logic [dlce_pkg::ShiftW-1:0] unit_shift_i;
  logic [dlce_pkg::LoopW-1:0]  unit_passes_i;
  logic [dlce_pkg::LoopW-1:0]  inner_passes_i;
  logic [dlce_pkg::CountW-1:0] total_count_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [dlce_pkg::AddrW-1:0]  out_main_addr_o;
  logic [dlce_pkg::AddrW-1:0]  out_local_addr_o;
  logic [dlce_pkg::MaskW-1:0]  out_cluster_mask_o;
  logic [dlce_pkg::MaskW-1:0]  out_unit_mask_o;
  logic                        is_last_o;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;

  dma_loop_command_expander #(
    .MAX_COMMANDS(MaxCommands),
    .MASK_WIDTH  (MaskWidth)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .base_main_addr_i   (base_main_addr_i),
    .base_local_addr_i  (base_local_addr_i),
    .base_cluster_mask_i(base_cluster_mask_i),
    .base_unit_mask_i   (base_unit_mask_i),
    .main_step_i        (main_step_i),
    .local_step_i       (local_step_i),
    .cluster_shift_i    (cluster_shift_i),
    .cluster_passes_i   (cluster_passes_i),
    .unit_shift_i       (unit_shift_i),
    .unit_passes_i      (unit_passes_i),
    .inner_passes_i     (inner_passes_i),
    .total_count_i      (total_count_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_main_addr_o    (out_main_addr_o),
    .out_local_addr_o   (out_local_addr_o),
    .out_cluster_mask_o (out_cluster_mask_o),
    .out_unit_mask_o    (out_unit_mask_o),
    .is_last_o          (is_last_o)
  );

  dma_loop_command_checker #(
    .MAX_COMMANDS(MaxCommands),
    .MASK_WIDTH  (MaskWidth)
  ) checker_inst (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .base_main_addr_i   (base_main_addr_i),
    .base_local_addr_i  (base_local_addr_i),
    .base_cluster_mask_i(base_cluster_mask_i),
    .base_unit_mask_i   (base_unit_mask_i),
    .main_step_i        (main_step_i),
    .local_step_i       (local_step_i),
    .cluster_shift_i    (cluster_shift_i),
    .cluster_passes_i   (cluster_passes_i),
    .unit_shift_i       (unit_shift_i),
    .unit_passes_i      (unit_passes_i),
    .inner_passes_i     (inner_passes_i),
    .total_count_i      (total_count_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_main_addr_i    (out_main_addr_o),
    .out_local_addr_i   (out_local_addr_o),
    .out_cluster_mask_i (out_cluster_mask_o),
    .out_unit_mask_i    (out_unit_mask_o),
    .is_last_i          (is_last_o),
    .fail_count_o       (fail_count),
    .pending_count_o    (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 30);
  end

  task automatic send_loop_word(input loop_word_t w);
    while (!no_idle && $urandom_range(99) < 30) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i          <= 1'b1;
    base_main_addr_i    <= w.main_addr;
    base_local_addr_i   <= w.local_addr;
    base_cluster_mask_i <= w.cl_mask;
    base_unit_mask_i    <= w.un_mask;
    main_step_i         <= w.main_step;
    local_step_i        <= w.local_step;
    cluster_shift_i     <= w.cl_shift;
    cluster_passes_i    <= w.cluster_passes;
    unit_shift_i        <= w.un_shift;
    unit_passes_i       <= w.unit_passes;
    inner_passes_i      <= w.inner_passes;
    total_count_i       <= w.total_count;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [31:0] random_step();
    if ($urandom_range(1)) return $urandom();
    return 32'(int'($urandom_range(64)) - 32);
  endfunction

  function automatic loop_word_t random_loop_word();
    loop_word_t w;
    w.main_addr  = $urandom();
    w.local_addr = $urandom();
    w.cl_mask    = $urandom_range(2) == 0 ? (32'd1 << $urandom_range(31)) : $urandom();
    w.un_mask    = $urandom_range(2) == 0 ? (32'd1 << $urandom_range(31)) : $urandom();
    w.main_step  = random_step();
    w.local_step = random_step();
    w.cl_shift   = dlce_pkg::ShiftW'($urandom_range(31));
    w.un_shift   = dlce_pkg::ShiftW'($urandom_range(31));
    if ($urandom_range(9) == 0) begin
      w.cluster_passes = dlce_pkg::LoopW'($urandom_range(63));
      w.unit_passes    = dlce_pkg::LoopW'($urandom_range(63));
      w.inner_passes   = dlce_pkg::LoopW'($urandom_range(63));
    end else begin
      w.cluster_passes = dlce_pkg::LoopW'($urandom_range(3));
      w.unit_passes    = dlce_pkg::LoopW'($urandom_range(3));
      w.inner_passes   = dlce_pkg::LoopW'($urandom_range(3));
    end
    w.total_count = dlce_pkg::CountW'($urandom_range(9) == 0 ? $urandom_range(127, 65)
                                                              : $urandom_range(64));
    return w;
  endfunction

  initial begin
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    out_stall_i         = 1'b0;
    base_main_addr_i    = '0;
    base_local_addr_i   = '0;
    base_cluster_mask_i = '0;
    base_unit_mask_i    = '0;
    main_step_i         = '0;
    local_step_i        = '0;
    cluster_shift_i     = '0;
    cluster_passes_i    = '0;
    unit_shift_i        = '0;
    unit_passes_i       = '0;
    inner_passes_i      = '0;
    total_count_i       = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero count, single command
    send_loop_word(loop_word_t'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                5'd0, 6'd0, 5'd0, 6'd0, 6'd0, 7'd0});
    // everything at its top value, count at the command limit
    send_loop_word(loop_word_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                5'd31, 6'd63, 5'd31, 6'd63, 6'd63, 7'd64});
    // loops end before count, local reset and unit mask restore
    send_loop_word(loop_word_t'{32'h0000_1000, 32'h0000_0200, 32'h0000_0001,
                                32'h0000_0001, 32'h0000_0004, 32'h0000_0008,
                                5'd1, 6'd1, 5'd2, 6'd1, 6'd1, 7'd64});
    send_loop_word(loop_word_t'{32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_00F0,
                                32'h0000_000F, 32'h0000_0010, 32'h0000_0020,
                                5'd4, 6'd63, 5'd4, 6'd63, 6'd63, 7'd1});
    // counts beyond the limit saturate
    send_loop_word(loop_word_t'{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0003,
                                32'h0000_0005, 32'h0000_0100, 32'h0000_0040,
                                5'd3, 6'd63, 5'd1, 6'd63, 6'd63, 7'd127});
    send_loop_word(loop_word_t'{32'h0000_0000, 32'h0000_8000, 32'h8000_0001,
                                32'h4000_0002, 32'h0000_0001, 32'h0000_0002,
                                5'd1, 6'd3, 5'd1, 6'd3, 6'd3, 7'd65});
    // negative steps
    send_loop_word(loop_word_t'{32'h0000_0010, 32'h0000_0008, 32'h0000_0001,
                                32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFC,
                                5'd0, 6'd0, 5'd0, 6'd0, 6'd15, 7'd16});
    send_loop_word(loop_word_t'{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0002,
                                32'h0000_0004, 32'h7FFF_FFFF, 32'h8000_0000,
                                5'd2, 6'd1, 5'd3, 6'd2, 6'd4, 7'd30});
    // zero shifts keep masks
    send_loop_word(loop_word_t'{32'h0000_0100, 32'h0000_0040, 32'hDEAD_BEEF,
                                32'hCAFE_F00D, 32'h0000_0004, 32'hFFFF_FFFF,
                                5'd0, 6'd2, 5'd0, 6'd2, 6'd2, 7'd27});
    // single bit pushed out by top shift
    send_loop_word(loop_word_t'{32'h0000_0000, 32'h0000_0000, 32'h0000_0001,
                                32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                                5'd31, 6'd3, 5'd31, 6'd2, 6'd0, 7'd64});
    // unit loop alone
    send_loop_word(loop_word_t'{32'h0000_2000, 32'h0000_0300, 32'h0000_0001,
                                32'h0000_0001, 32'h0000_0010, 32'h0000_0004,
                                5'd1, 6'd0, 5'd1, 6'd63, 6'd0, 7'd64});
    // cluster loop alone
    send_loop_word(loop_word_t'{32'h0000_3000, 32'h0000_0400, 32'h0000_0001,
                                32'h0000_0003, 32'h0000_0008, 32'h0000_0004,
                                5'd1, 6'd63, 5'd1, 6'd0, 6'd0, 7'd64});
    send_loop_word(loop_word_t'{32'h0000_4000, 32'h0000_0500, 32'h0000_0007,
                                32'h0000_0007, 32'h0000_0008, 32'h0000_0004,
                                5'd5, 6'd63, 5'd5, 6'd63, 6'd63, 7'd0});
    // loops and count end together
    send_loop_word(loop_word_t'{32'h0000_5000, 32'h0000_0600, 32'h0000_0011,
                                32'h0000_0022, 32'h0000_0020, 32'h0000_0010,
                                5'd4, 6'd1, 5'd8, 6'd3, 6'd7, 7'd64});
    // main address wraps
    send_loop_word(loop_word_t'{32'hFFFF_FFF0, 32'hFFFF_FFF8, 32'h0000_0001,
                                32'h0000_0001, 32'h0000_0010, 32'h0000_0004,
                                5'd1, 6'd0, 5'd1, 6'd0, 6'd7, 7'd8});

    for (int k = 0; k < RandomWords; k++) begin
      no_idle = (k >= 50 && k < 80);
      send_loop_word(random_loop_word());
    end
    no_idle = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
